/* rtl/assert_macros.svh */
// Assertion helper macros for the ray/plane/triangle intersect block.
// Included by the top level; no other dependencies.

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rpti_pkg.sv */
// Shared constants, types and helpers for the ray/plane/triangle intersect block.
// No dependencies; imported by every RTL module of the block.

package rpti_pkg;

    // fixed point formats
    localparam int COORD_BITS     = 21;
    localparam int DIST_FRAC_BITS = 16;
    localparam int VEC_W          = 63;
    localparam int VEC3_W         = 3 * COORD_BITS;
    localparam int DIST_W         = 32;
    localparam int INT_BITS       = DIST_W - DIST_FRAC_BITS;
    localparam int IN_TDATA_W     = ((2 * VEC_W + 7) / 8) * 8;

    // plane equation widths
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_NUM_W = 2 * COORD_BITS + 1;
    localparam int PROD_DEN_W = 2 * COORD_BITS;
    localparam int NUM_W      = 2 * COORD_BITS + 3;
    localparam int DEN_W      = 2 * COORD_BITS + 2;
    localparam int SATCMP_W   = DEN_W + INT_BITS;

    // divider: one quotient bit per stage
    localparam int DIV_STEPS = DIST_W;

    // hit point widths
    localparam int TD_W     = DIST_W + 1 + COORD_BITS;
    localparam int PT_RAW_W = TD_W - DIST_FRAC_BITS + 1;
    localparam int P_W      = 40;
    localparam int PC_W     = (PT_RAW_W > P_W) ? PT_RAW_W : P_W;
    localparam logic signed [PC_W-1:0] PT_MAX = {{(PC_W - P_W + 1){1'b0}}, {(P_W - 1){1'b1}}};
    localparam logic signed [PC_W-1:0] PT_MIN = ~PT_MAX;

    // edge test widths
    localparam int EDGE_STAGES = 5;
    localparam int E_W   = COORD_BITS + 1;
    localparam int FP_W  = 2 * E_W;
    localparam int F_W   = FP_W + 1;
    localparam int FL    = (F_W + 1) / 2;
    localparam int FS_W  = FL + 1;
    localparam int MP_W  = FS_W + E_W;
    localparam int MA_W  = F_W + E_W;
    localparam int H_W   = F_W + E_W + 1;
    localparam int HL    = (H_W + 2) / 3;
    localparam int HS_W  = HL + 1;
    localparam int W_W   = P_W + 1;
    localparam int WL    = W_W / 2;
    localparam int WP_W  = WL + 1;
    localparam int PP_W  = HS_W + WP_W;
    localparam int C_W   = PP_W + WL + 1;
    localparam int ACC_W = C_W + 2 * HL + 3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SHAPE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_NORMAL = 3'd4;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // x in the lowest bits
    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec_t;

    // per-ray info that rides alongside the divider
    typedef struct packed {
        vec_t origin;
        vec_t dir;
        logic miss;
        logic sat;
    } side_t;

    function automatic coord_t vcomp(input vec_t v, input int k);
        coord_t c;
        case (k)
            0:       c = v.x;
            1:       c = v.y;
            default: c = v.z;
        endcase
        return c;
    endfunction

endpackage

/* rtl/ray_plane_triangle_intersect.sv */
// Ray against plane or triangle intersect, top level: config, plane math, output.
// Depends on rpti_pkg, rpti_div, rpti_edge and assert_macros.svh.
//
//   channel | dir | handshake              | payload
//   s_      | in  | s_tvalid / s_tready    | s_tdata: ray_origin, ray_direction
//   m_      | out | m_tvalid / m_tready    | m_tdata: distance, m_tuser: hit
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One ray per cycle while the output is not stalled; the longest part of the pipeline is the 32-stage divider.
// Reset (aresetn low at a clock edge) empties the pipeline and restores config.
// A stalled output holds; upstream stages keep filling empty slots until full.
// Edge terms follow a vertex write through free-running registers e, g, fpa, fpb, f, mh/ml, ma, mb and h.

`include "assert_macros.svh"

module ray_plane_triangle_intersect
    import rpti_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // word: ray_origin [62:0], ray_direction [125:63], zero pad
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // word: distance [31:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DIST_W-1:0]     m_tdata,
    // hit [0]
    output logic                  m_tuser,
    // config writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VEC_W-1:0]      cfg_data
);

    localparam int S_IN    = 0;
    localparam int S_PROD  = 1;
    localparam int S_SUM   = 2;
    localparam int S_ABS   = 3;
    localparam int S_SAT   = 4;
    localparam int S_DIV0  = 5;
    localparam int S_MUL   = S_DIV0 + DIV_STEPS;
    localparam int S_PT    = S_MUL + 1;
    localparam int S_EDGE0 = S_PT + 1;
    localparam int S_OUT   = S_EDGE0 + EDGE_STAGES;
    localparam int NST     = S_OUT + 1;

    // configuration registers
    logic             mode_reg;
    logic [VEC_W-1:0] va_reg;
    logic [VEC_W-1:0] vb_reg;
    logic [VEC_W-1:0] vc_reg;
    logic [VEC_W-1:0] vn_reg;
    vec_t             va;
    vec_t             vb;
    vec_t             vc;
    vec_t             vn;

    assign cfg_ready = 1'b1;
    assign va = vec_t'(va_reg[VEC3_W-1:0]);
    assign vb = vec_t'(vb_reg[VEC3_W-1:0]);
    assign vc = vec_t'(vc_reg[VEC3_W-1:0]);
    assign vn = vec_t'(vn_reg[VEC3_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            va_reg   <= '0;
            vb_reg   <= '0;
            vc_reg   <= '0;
            vn_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SHAPE_MODE:   mode_reg <= cfg_data[0];
                REG_VERTEX_A:     va_reg   <= cfg_data;
                REG_VERTEX_B:     vb_reg   <= cfg_data;
                REG_VERTEX_C:     vc_reg   <= cfg_data;
                REG_PLANE_NORMAL: vn_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and enables; a stage loads when empty or draining
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] ce;

    always_comb begin
        ce[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            ce[i] = !vld_reg[i] || ce[i+1];
        end
        vld_next = ({vld_reg[NST-2:0], s_tvalid} & ce) | (vld_reg & ~ce);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = ce[S_IN];
    assign m_tvalid = vld_reg[S_OUT];

    // input word and a - o
    vec_t                    origin_in;
    vec_t                    dir_in;
    vec_t                    o1_reg;
    vec_t                    d1_reg;
    logic signed [DIFF_W-1:0] diff_reg [3];

    assign origin_in = vec_t'(s_tdata[VEC3_W-1:0]);
    assign dir_in    = vec_t'(s_tdata[VEC_W +: VEC3_W]);

    always_ff @(posedge aclk) begin
        if (ce[S_IN]) begin
            o1_reg <= origin_in;
            d1_reg <= dir_in;
            for (int k = 0; k < 3; k++) begin
                diff_reg[k] <= DIFF_W'(vcomp(va, k)) - DIFF_W'(vcomp(origin_in, k));
            end
        end
    end

    // products for numerator and denominator
    vec_t                         o2_reg;
    vec_t                         d2_reg;
    logic signed [PROD_NUM_W-1:0] pn_reg [3];
    logic signed [PROD_DEN_W-1:0] pd_reg [3];

    always_ff @(posedge aclk) begin
        if (ce[S_PROD]) begin
            o2_reg <= o1_reg;
            d2_reg <= d1_reg;
            for (int k = 0; k < 3; k++) begin
                pn_reg[k] <= vcomp(vn, k) * diff_reg[k];
                pd_reg[k] <= vcomp(vn, k) * vcomp(d1_reg, k);
            end
        end
    end

    // dot sums
    vec_t                    o3_reg;
    vec_t                    d3_reg;
    logic signed [NUM_W-1:0] num_reg;
    logic signed [DEN_W-1:0] den_reg;

    always_ff @(posedge aclk) begin
        if (ce[S_SUM]) begin
            o3_reg  <= o2_reg;
            d3_reg  <= d2_reg;
            num_reg <= NUM_W'(pn_reg[0]) + NUM_W'(pn_reg[1]) + NUM_W'(pn_reg[2]);
            den_reg <= DEN_W'(pd_reg[0]) + DEN_W'(pd_reg[1]) + DEN_W'(pd_reg[2]);
        end
    end

    // miss on zero or sign mismatch; magnitudes
    vec_t             o4_reg;
    vec_t             d4_reg;
    logic             abs_miss_reg;
    logic [NUM_W-1:0] un_reg;
    logic [DEN_W-1:0] ud_reg;

    always_ff @(posedge aclk) begin
        if (ce[S_ABS]) begin
            o4_reg       <= o3_reg;
            d4_reg       <= d3_reg;
            abs_miss_reg <= (den_reg == '0) || (num_reg == '0)
                          || (num_reg[NUM_W-1] != den_reg[DEN_W-1]);
            un_reg       <= num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
            ud_reg       <= den_reg[DEN_W-1] ? $unsigned(-den_reg) : $unsigned(den_reg);
        end
    end

    // saturation check and divider setup
    side_t             side4_reg;
    logic [DEN_W-1:0]  rem4_reg;
    logic [DEN_W-1:0]  ud4_reg;
    logic [DIST_W-1:0] nlow4_reg;

    always_ff @(posedge aclk) begin
        if (ce[S_SAT]) begin
            side4_reg.origin <= o4_reg;
            side4_reg.dir    <= d4_reg;
            side4_reg.miss   <= abs_miss_reg;
            side4_reg.sat    <= SATCMP_W'(un_reg) >= {ud_reg, {INT_BITS{1'b0}}};
            rem4_reg         <= DEN_W'(un_reg >> INT_BITS);
            ud4_reg          <= ud_reg;
            nlow4_reg        <= DIST_W'({un_reg, {DIST_FRAC_BITS{1'b0}}});
        end
    end

    // quotient, one bit per stage
    logic [DIST_W-1:0] q_div;
    side_t             side_div;

    rpti_div u_div (
        .aclk     (aclk),
        .ce       (ce[S_DIV0 +: DIV_STEPS]),
        .rem_in   (rem4_reg),
        .ud_in    (ud4_reg),
        .nlow_in  (nlow4_reg),
        .side_in  (side4_reg),
        .q_out    (q_div),
        .side_out (side_div)
    );

    // t times direction
    logic [DIST_W-1:0]       t_next;
    logic [DIST_W-1:0]       t5_reg;
    logic                    miss5_reg;
    vec_t                    o5_reg;
    logic signed [TD_W-1:0]  tdp_reg [3];

    assign t_next = side_div.sat ? '1 : q_div;

    always_ff @(posedge aclk) begin
        if (ce[S_MUL]) begin
            t5_reg    <= t_next;
            miss5_reg <= side_div.miss;
            o5_reg    <= side_div.origin;
            for (int k = 0; k < 3; k++) begin
                tdp_reg[k] <= $signed({1'b0, t_next}) * vcomp(side_div.dir, k);
            end
        end
    end

    // hit point, floor shift and clamp to signed 40 bits
    logic signed [TD_W-1:0] tsh   [3];
    logic signed [PC_W-1:0] psum  [3];
    logic signed [PC_W-1:0] pclmp [3];
    logic signed [P_W-1:0]  p_reg [3];
    logic [DIST_W-1:0]      t6_reg;
    logic                   miss6_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            tsh[k]  = tdp_reg[k] >>> DIST_FRAC_BITS;
            psum[k] = PC_W'(vcomp(o5_reg, k)) + PC_W'(tsh[k]);
            if (psum[k] > PT_MAX) begin
                pclmp[k] = PT_MAX;
            end else if (psum[k] < PT_MIN) begin
                pclmp[k] = PT_MIN;
            end else begin
                pclmp[k] = psum[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce[S_PT]) begin
            t6_reg    <= t5_reg;
            miss6_reg <= miss5_reg;
            for (int k = 0; k < 3; k++) begin
                p_reg[k] <= P_W'(pclmp[k]);
            end
        end
    end

    // edge tests for the triangle edges ab, bc and ca
    logic [2:0] outside;

    rpti_edge u_edge_ab (
        .aclk    (aclk),
        .ce      (ce[S_EDGE0 +: EDGE_STAGES]),
        .s_vec   (va),
        .q_vec   (vb),
        .r_vec   (vc),
        .pt      (p_reg),
        .outside (outside[0])
    );

    rpti_edge u_edge_bc (
        .aclk    (aclk),
        .ce      (ce[S_EDGE0 +: EDGE_STAGES]),
        .s_vec   (vb),
        .q_vec   (vc),
        .r_vec   (va),
        .pt      (p_reg),
        .outside (outside[1])
    );

    rpti_edge u_edge_ca (
        .aclk    (aclk),
        .ce      (ce[S_EDGE0 +: EDGE_STAGES]),
        .s_vec   (vc),
        .q_vec   (va),
        .r_vec   (vb),
        .pt      (p_reg),
        .outside (outside[2])
    );

    // t and miss ride alongside the edge stages
    logic [DIST_W-1:0] te_reg    [EDGE_STAGES];
    logic              misse_reg [EDGE_STAGES];

    for (genvar i = 0; i < EDGE_STAGES; i++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (ce[S_EDGE0 + i]) begin
                if (i == 0) begin
                    te_reg[i]    <= t6_reg;
                    misse_reg[i] <= miss6_reg;
                end else begin
                    te_reg[i]    <= te_reg[(i == 0) ? 0 : i - 1];
                    misse_reg[i] <= misse_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    // output register
    logic              hit_next;
    logic              hit_reg;
    logic [DIST_W-1:0] dist_reg;

    assign hit_next = !misse_reg[EDGE_STAGES-1] && !(mode_reg && (|outside));

    always_ff @(posedge aclk) begin
        if (ce[S_OUT]) begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? te_reg[EDGE_STAGES-1] : '0;
        end
    end

    assign m_tdata = dist_reg;
    assign m_tuser = hit_reg;

    // checks
    `ASSERT_IMP(a_blocked_only_when_full, aclk, aresetn, !s_tready, &vld_reg, "input blocked with a free stage")
    `ASSERT_NXT(a_zero_den_is_miss, aclk, aresetn, vld_reg[S_SUM] && ce[S_ABS] && (den_reg == '0), abs_miss_reg, "zero denominator not flagged as miss")
    `ASSERT_IMP(a_div_rem_bound, aclk, aresetn, vld_reg[S_SAT] && !side4_reg.miss && !side4_reg.sat, rem4_reg < ud4_reg, "divider start remainder not below divisor")

endmodule

/* rtl/rpti_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with side info.
// Depends on rpti_pkg.

module rpti_div
    import rpti_pkg::*;
(
    input  logic                 aclk,
    input  logic [DIV_STEPS-1:0] ce,
    input  logic [DEN_W-1:0]     rem_in,
    input  logic [DEN_W-1:0]     ud_in,
    input  logic [DIST_W-1:0]    nlow_in,
    input  side_t                side_in,
    output logic [DIST_W-1:0]    q_out,
    output side_t                side_out
);

    logic [DEN_W-1:0]  rem_reg  [DIV_STEPS];
    logic [DEN_W-1:0]  ud_reg   [DIV_STEPS];
    logic [DIST_W-1:0] n_reg    [DIV_STEPS];
    logic [DIST_W-1:0] q_reg    [DIV_STEPS];
    side_t             side_reg [DIV_STEPS];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [DEN_W-1:0]  rem_cur;
        logic [DEN_W-1:0]  ud_cur;
        logic [DIST_W-1:0] n_cur;
        logic [DIST_W-1:0] q_cur;
        side_t             side_cur;
        logic [DEN_W:0]    shifted;
        logic [DEN_W:0]    trial;
        logic [DEN_W-1:0]  rem_next;

        if (i == 0) begin : g_first
            assign rem_cur  = rem_in;
            assign ud_cur   = ud_in;
            assign n_cur    = nlow_in;
            assign q_cur    = '0;
            assign side_cur = side_in;
        end else begin : g_rest
            assign rem_cur  = rem_reg[i-1];
            assign ud_cur   = ud_reg[i-1];
            assign n_cur    = n_reg[i-1];
            assign q_cur    = q_reg[i-1];
            assign side_cur = side_reg[i-1];
        end

        // shift in next dividend bit, trial subtract
        always_comb begin
            shifted  = {rem_cur, n_cur[DIST_W-1]};
            trial    = shifted - {1'b0, ud_cur};
            rem_next = trial[DEN_W] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (ce[i]) begin
                rem_reg[i]  <= rem_next;
                ud_reg[i]   <= ud_cur;
                n_reg[i]    <= {n_cur[DIST_W-2:0], 1'b0};
                q_reg[i]    <= {q_cur[DIST_W-2:0], ~trial[DEN_W]};
                side_reg[i] <= side_cur;
            end
        end
    end

    assign q_out    = q_reg[DIV_STEPS-1];
    assign side_out = side_reg[DIV_STEPS-1];

endmodule

/* rtl/rpti_edge.sv */
// One triangle edge test: sign of dot(cross(e, r - s), cross(e, p - s)).
// Depends on rpti_pkg. Edge terms are precomputed from the vertex registers.

module rpti_edge
    import rpti_pkg::*;
(
    input  logic                   aclk,
    input  logic [EDGE_STAGES-1:0] ce,
    input  vec_t                   s_vec,
    input  vec_t                   q_vec,
    input  vec_t                   r_vec,
    input  logic signed [P_W-1:0]  pt [3],
    output logic                   outside
);

    // f . (e x w) == w . (f x e), so h = f x e depends on vertices only
    logic signed [E_W-1:0]  e_reg   [3];
    logic signed [E_W-1:0]  g_reg   [3];
    logic signed [FP_W-1:0] fpa_reg [3];
    logic signed [FP_W-1:0] fpb_reg [3];
    logic signed [F_W-1:0]  f_reg   [3];
    logic signed [FS_W-1:0] fh      [3];
    logic signed [FS_W-1:0] fl      [3];
    logic signed [MP_W-1:0] mha_reg [3];
    logic signed [MP_W-1:0] mla_reg [3];
    logic signed [MP_W-1:0] mhb_reg [3];
    logic signed [MP_W-1:0] mlb_reg [3];
    logic signed [MA_W-1:0] ma_reg  [3];
    logic signed [MA_W-1:0] mb_reg  [3];
    logic signed [H_W-1:0]  h_reg   [3];

    // per-ray pipeline
    logic signed [W_W-1:0]   w_reg    [3];
    logic signed [HS_W-1:0]  hc       [3][3];
    logic signed [WP_W-1:0]  wc       [3][2];
    logic signed [PP_W-1:0]  pp_reg   [3][3][2];
    logic signed [C_W-1:0]   c_reg    [3][3];
    logic signed [ACC_W-1:0] comp_reg [3];
    logic signed [ACC_W-1:0] dot_next;
    logic                    outside_reg;

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        // split f into a signed high half and an unsigned low half
        assign fl[k] = $signed({1'b0, f_reg[k][FL-1:0]});
        assign fh[k] = FS_W'($signed(f_reg[k][F_W-1:FL]));

        // vertex-side terms, free running
        always_ff @(posedge aclk) begin
            e_reg[k]   <= E_W'(vcomp(q_vec, k)) - E_W'(vcomp(s_vec, k));
            g_reg[k]   <= E_W'(vcomp(r_vec, k)) - E_W'(vcomp(s_vec, k));
            fpa_reg[k] <= e_reg[K1] * g_reg[K2];
            fpb_reg[k] <= e_reg[K2] * g_reg[K1];
            f_reg[k]   <= F_W'(fpa_reg[k]) - F_W'(fpb_reg[k]);
            mha_reg[k] <= fh[K1] * e_reg[K2];
            mla_reg[k] <= fl[K1] * e_reg[K2];
            mhb_reg[k] <= fh[K2] * e_reg[K1];
            mlb_reg[k] <= fl[K2] * e_reg[K1];
            ma_reg[k]  <= (MA_W'(mha_reg[k]) <<< FL) + MA_W'(mla_reg[k]);
            mb_reg[k]  <= (MA_W'(mhb_reg[k]) <<< FL) + MA_W'(mlb_reg[k]);
            h_reg[k]   <= H_W'(ma_reg[k]) - H_W'(mb_reg[k]);
        end

        // operand slices for the partial products
        assign hc[k][0] = $signed({1'b0, h_reg[k][HL-1:0]});
        assign hc[k][1] = $signed({1'b0, h_reg[k][2*HL-1:HL]});
        assign hc[k][2] = HS_W'($signed(h_reg[k][H_W-1:2*HL]));
        assign wc[k][0] = $signed({1'b0, w_reg[k][WL-1:0]});
        assign wc[k][1] = WP_W'($signed(w_reg[k][W_W-1:WL]));

        // point relative to edge start
        always_ff @(posedge aclk) begin
            if (ce[0]) begin
                w_reg[k] <= W_W'(pt[k]) - W_W'(vcomp(s_vec, k));
            end
        end

        // partial products
        always_ff @(posedge aclk) begin
            if (ce[1]) begin
                for (int j = 0; j < 3; j++) begin
                    for (int m = 0; m < 2; m++) begin
                        pp_reg[k][j][m] <= hc[k][j] * wc[k][m];
                    end
                end
            end
        end

        // merge the two w halves
        always_ff @(posedge aclk) begin
            if (ce[2]) begin
                for (int j = 0; j < 3; j++) begin
                    c_reg[k][j] <= C_W'(pp_reg[k][j][0]) + (C_W'(pp_reg[k][j][1]) <<< WL);
                end
            end
        end

        // merge the three h slices
        always_ff @(posedge aclk) begin
            if (ce[3]) begin
                comp_reg[k] <= ACC_W'(c_reg[k][0]) + (ACC_W'(c_reg[k][1]) <<< HL)
                             + (ACC_W'(c_reg[k][2]) <<< (2 * HL));
            end
        end
    end

    // dot product sign
    assign dot_next = comp_reg[0] + comp_reg[1] + comp_reg[2];

    always_ff @(posedge aclk) begin
        if (ce[4]) begin
            outside_reg <= dot_next[ACC_W-1];
        end
    end

    assign outside = outside_reg;

endmodule
